@@ sv/double_ended_queue_macros.svh @@
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
// Shared types, codes and sizes for the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int CAPACITY  = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW   = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_FW   = $clog2(CMDQ_DEPTH + 1);

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  value;
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/deq_front.sv @@
// Front end: accepts input words, decodes the command, queues it for the back end.
`default_nettype none

module deq_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  command,
    input  wire logic signed [deq_pkg::DATA_W-1:0] item_value,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output deq_pkg::cmd_t                    cmd
);

    deq_pkg::cmd_t                 queue_reg [deq_pkg::CMDQ_DEPTH];
    logic [deq_pkg::CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [deq_pkg::CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [deq_pkg::CMDQ_FW-1:0]   fill_reg, fill_next;
    deq_pkg::cmd_t                 decoded;
    logic                          known;
    logic                          push;
    logic                          pop;

    always_comb
    begin
        known         = 1'b1;
        decoded.value = item_value;
        decoded.op    = deq_pkg::OP_DUMP;
        case (command)
            deq_pkg::CMD_PUSH_FRONT: decoded.op = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::CMD_PUSH_BACK:  decoded.op = deq_pkg::OP_PUSH_BACK;
            deq_pkg::CMD_POP_FRONT:  decoded.op = deq_pkg::OP_POP_FRONT;
            deq_pkg::CMD_POP_BACK:   decoded.op = deq_pkg::OP_POP_BACK;
            deq_pkg::CMD_DUMP:       decoded.op = deq_pkg::OP_DUMP;
            default:                 known      = 1'b0;
        endcase
    end

    assign in_ready  = (fill_reg != deq_pkg::CMDQ_FW'(deq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // drop unknown codes at the door: they cause no result
    assign push = in_valid && in_ready && known;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == deq_pkg::CMDQ_AW'(deq_pkg::CMDQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == deq_pkg::CMDQ_AW'(deq_pkg::CMDQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

@@ sv/deq_back.sv @@
// Back end: ring store, front index and count, output register.
`default_nettype none

module deq_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire deq_pkg::cmd_t                     cmd,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]      out_value,
    output logic [1:0]                             status,
    output logic                                   last_result
);

    localparam int AW = deq_pkg::ADDR_W;
    localparam int CW = deq_pkg::COUNT_W;

    deq_pkg::back_state_t        state_reg, state_next;
    logic [AW-1:0]               front_reg, front_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic                        dump_reg, dump_next;
    logic                        out_valid_reg, out_valid_next;
    logic [deq_pkg::DATA_W-1:0]  out_value_reg, out_value_next;
    logic [1:0]                  status_reg, status_next;
    logic                        last_reg, last_next;

    logic                        out_free;
    logic                        take;
    logic                        full;
    logic                        empty;
    logic                        last_entry;
    logic [AW-1:0]               offset;
    logic [AW:0]                 slot_sum;
    logic [AW-1:0]               slot;
    logic [AW-1:0]               front_dec;
    logic [AW-1:0]               front_inc;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [deq_pkg::DATA_W-1:0]  rd_data;

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == deq_pkg::S_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign full      = (count_reg == CW'(deq_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign last_entry = !dump_reg || ((CW'(idx_reg) + CW'(1)) == count_reg);

    // ring position of front + offset, one compare and subtract
    always_comb
    begin
        offset = '0;
        if (state_reg == deq_pkg::S_READ)
        begin
            offset = idx_reg + 1'b1;
        end
        else
        begin
            case (cmd.op)
                deq_pkg::OP_PUSH_BACK: offset = AW'(count_reg);
                deq_pkg::OP_POP_BACK:  offset = AW'(count_reg - 1'b1);
                default:               offset = '0;
            endcase
        end
    end

    assign slot_sum  = (AW+1)'(front_reg) + (AW+1)'(offset);
    assign slot      = (slot_sum >= (AW+1)'(deq_pkg::CAPACITY))
                     ? AW'(slot_sum - (AW+1)'(deq_pkg::CAPACITY)) : AW'(slot_sum);
    assign front_dec = (front_reg == '0) ? AW'(deq_pkg::CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == AW'(deq_pkg::CAPACITY - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        dump_next      = dump_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = slot;
        rd_en          = 1'b0;
        rd_addr        = slot;

        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (take)
                begin
                    out_value_next = '0;
                    last_next      = 1'b1;
                    status_next    = deq_pkg::STATUS_OK;
                    case (cmd.op)
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.op == deq_pkg::OP_PUSH_FRONT)
                                begin
                                    wr_addr    = front_dec;
                                    front_next = front_dec;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                dump_next  = 1'b0;
                                state_next = deq_pkg::S_READ;
                                if (cmd.op == deq_pkg::OP_POP_FRONT)
                                begin
                                    front_next = front_inc;
                                end
                            end
                        end
                        deq_pkg::OP_DUMP:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = '0;
                                dump_next  = 1'b1;
                                state_next = deq_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                    endcase
                end
            end
            deq_pkg::S_READ:
            begin
                // hold read data until the output register frees, then fetch the next entry
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_data;
                    status_next    = deq_pkg::STATUS_OK;
                    last_next      = last_entry;
                    if (last_entry)
                    begin
                        state_next = deq_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            dump_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            dump_reg      <= dump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

endmodule

`default_nettype wire

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: command front end, ring-store back end.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | command, item_value
//  output   | out_valid / out_ready| out_value, status, last_result
//
//  A push, or any error answer, goes straight to the output register; a pop
//  passes through a ring-store read, then the output register.
//  A dump of N entries streams one word per cycle while the output does not
//  stall, after a first store read; the store's registered read sets this pace.
//  A two-word command queue keeps taking input while the back end works.
//  Reset clears the front index, the count and all handshake state; the store
//  needs no clearing pass. Output stalls hold the back end in place.
`default_nettype none
`include "double_ended_queue_macros.svh"

module double_ended_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        command,
    input  wire logic signed [deq_pkg::DATA_W-1:0] item_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]      out_value,
    output logic [1:0]                             status,
    output logic                                   last_result
);

    logic          cmd_valid;
    logic          cmd_ready;
    deq_pkg::cmd_t cmd;

    deq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .item_value (item_value),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    deq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .status      (status),
        .last_result (last_result)
    );

    `DEQ_ASSERT_NOW(a_error_is_last,
        out_valid && (status == deq_pkg::STATUS_EMPTY || status == deq_pkg::STATUS_FULL),
        last_result && (out_value == '0), "error word must be final and carry zero")
    `DEQ_ASSERT_NOW(a_status_code,
        out_valid, status != 2'd3, "undefined status code on output")
    `DEQ_ASSERT_NEXT(a_no_take_while_stalled,
        out_valid && !out_ready && !cmd_valid, out_valid && $stable(out_value),
        "stalled output word changed")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the double-ended queue: directed, fill/drain and random traffic.
`timescale 1ns / 1ps

module tb_top;
    import deq_pkg::*;

    localparam logic [2:0] CMD_RESERVED_MAX = 3'd7;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        status;
        logic              last;
    } deq_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [2:0]               command;
    logic signed [DATA_W-1:0] item_value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     last_result;

    // Shadow copy of the deque, updated on every accepted command word.
    logic [DATA_W-1:0]  shadow_store [CAPACITY];
    logic [ADDR_W-1:0]  shadow_front;
    logic [COUNT_W-1:0] shadow_count;
    deq_word_t          expected_words [$];

    int error_count;
    int gap_percent;
    int stall_percent;

    double_ended_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .status      (status),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        $display("%0t: %s mismatch: got %08h expected %08h", $time, what, got, want);
    endtask

    function automatic void apply_deque_command(input logic [2:0] cmd,
                                                input logic [DATA_W-1:0] val);
        deq_word_t w;
        int        pos;
        int        i;
        w.value  = '0;
        w.status = STATUS_OK;
        w.last   = 1'b1;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count == CAPACITY)
                    w.status = STATUS_FULL;
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        shadow_front = ADDR_W'((int'(shadow_front) + CAPACITY - 1) % CAPACITY);
                        shadow_store[shadow_front] = val;
                    end
                    else
                    begin
                        pos = (int'(shadow_front) + int'(shadow_count)) % CAPACITY;
                        shadow_store[pos] = val;
                    end
                    shadow_count++;
                end
                expected_words.push_back(w);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    w.status = STATUS_EMPTY;
                else
                begin
                    if (cmd == CMD_POP_FRONT)
                    begin
                        pos = int'(shadow_front);
                        shadow_front = ADDR_W'((int'(shadow_front) + 1) % CAPACITY);
                    end
                    else
                        pos = (int'(shadow_front) + int'(shadow_count) - 1) % CAPACITY;
                    w.value = shadow_store[pos];
                    shadow_count--;
                end
                expected_words.push_back(w);
            end
            CMD_DUMP:
            begin
                if (shadow_count == 0)
                begin
                    w.status = STATUS_EMPTY;
                    expected_words.push_back(w);
                end
                else
                    for (i = 0; i < int'(shadow_count); i++)
                    begin
                        pos     = (int'(shadow_front) + i) % CAPACITY;
                        w.value = shadow_store[pos];
                        w.last  = (i == int'(shadow_count) - 1);
                        expected_words.push_back(w);
                    end
            end
            default:
                ; // reserved codes: no answer, queue untouched
        endcase
    endfunction

    // Predict on accepted commands first, then check the accepted output word.
    always @(posedge clk)
    begin : monitor
        deq_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_deque_command(command, item_value);
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word, out_value", out_value, '0);
                else
                begin
                    want = expected_words.pop_front();
                    if (out_value !== want.value)
                        report_mismatch("out_value", out_value, want.value);
                    if (status !== want.status)
                        report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
                    if (last_result !== want.last)
                        report_mismatch("last_result", DATA_W'(last_result),
                                        DATA_W'(want.last));
                end
            end
        end
    end

    // Output side: random stall bursts while stall_percent is nonzero.
    initial
    begin : receiver
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (stall_percent != 0 && $urandom_range(0, 99) < stall_percent)
            begin
                hold = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [2:0] cmd, input logic [DATA_W-1:0] val);
        int gap;
        if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent)
        begin
            gap = $urandom_range(1, 7);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= cmd;
        item_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold off input until every outstanding word has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (roll < 88)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (roll < 96)
            return CMD_DUMP;
        return 3'($urandom_range(int'(CMD_DUMP) + 1, int'(CMD_RESERVED_MAX)));
    endfunction

    task automatic test_empty_answers();
        int c;
        send_word(CMD_POP_FRONT, $urandom);
        send_word(CMD_POP_BACK, $urandom);
        send_word(CMD_DUMP, $urandom);
        for (c = int'(CMD_DUMP) + 1; c <= int'(CMD_RESERVED_MAX); c++)
            send_word(3'(c), $urandom);
    endtask

    task automatic test_single_entry();
        send_word(CMD_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}});
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}});
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_PUSH_FRONT, '1);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_POP_FRONT, '1);
    endtask

    task automatic test_end_order();
        send_word(CMD_PUSH_BACK, 32'h5555_5555);
        send_word(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        send_word(CMD_PUSH_BACK, 32'h0000_0001);
        send_word(CMD_DUMP, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_DUMP, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_DUMP, '0);
    endtask

    // Fill past capacity from both ends, dump the full queue, then drain past empty.
    task automatic test_fill_and_drain();
        int n;
        for (n = 0; n < CAPACITY + 3; n++)
            send_word($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
        send_word(CMD_DUMP, $urandom);
        for (n = 0; n < CAPACITY + 3; n++)
            send_word($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
        send_word(CMD_DUMP, $urandom);
    endtask

    task automatic test_random_mix(input int words);
        int n;
        int push_pct;
        push_pct = 45;
        for (n = 0; n < words; n++)
        begin
            if (n % 25 == 0)
            begin
                push_pct      = $urandom_range(25, 70);
                gap_percent   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 50);
                stall_percent = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 50);
            end
            if (n == words / 2)
                wait_for_drain();
            send_word(pick_command(push_pct), random_value());
        end
    endtask

    task automatic test_streaming_tail(input int words);
        int n;
        gap_percent   = 0;
        stall_percent = 0;
        for (n = 0; n < words; n++)
            send_word(pick_command(50), random_value());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_PUSH_FRONT;
        item_value    = '0;
        error_count   = 0;
        gap_percent   = 30;
        stall_percent = 30;
        shadow_front  = '0;
        shadow_count  = '0;
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_answers();
        test_single_entry();
        test_end_order();
        gap_percent   = 20;
        stall_percent = 20;
        test_fill_and_drain();
        test_random_mix(100);
        test_streaming_tail(30);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_front.sv
sv/deq_back.sv
sv/double_ended_queue.sv
verif/tb_top.sv
